// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define KFTC_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("kftc check failed");

// The consequent must hold in the same cycle as the antecedent.
`define KFTC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kftc check failed");

// The consequent must hold in the cycle after the antecedent.
`define KFTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kftc check failed");

`endif

// File: src/kftc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kftc_pkg
// Types and constants shared by the keyboard FIFO talk controller.
// ----------------------------------------------------------------------------
package kftc_pkg;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_HOST = 2'd1,
        OP_KEY  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_TEXT    = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    localparam logic [7:0] CMD_ID  = 8'h08;
    localparam logic [7:0] ID_BYTE = 8'h02;

    typedef struct packed {
        logic       alt_held;
        logic       ctrl_held;
        logic       shift_held;
        logic [7:0] in_byte;
        t_kind      event_kind;
        logic       cpu_talk;
        t_op        operation;
    } t_item;

    typedef struct packed {
        logic       accepted;
        logic       talk_line;
        logic [7:0] sent_byte;
        logic       byte_valid;
    } t_result;

endpackage

// File: src/kftc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kftc_engine
// Key and command queues, talk flag and the per-item update logic.
// ----------------------------------------------------------------------------
module kftc_engine #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic             i_layout_mode,
    input  kftc_pkg::t_item   i_item,
    output kftc_pkg::t_result o_result
);
    import kftc_pkg::*;

    localparam int CW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int KCW = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]     r_kq [QUEUE_DEPTH];
    logic [7:0]     r_cq [QUEUE_DEPTH];
    logic [KCW-1:0] r_kc;
    logic [CW-1:0]  r_cc;
    logic           r_talk;

    logic [7:0]     n_kq [QUEUE_DEPTH];
    logic [7:0]     n_cq [QUEUE_DEPTH];
    logic [KCW-1:0] n_kc;
    logic [CW-1:0]  n_cc;
    logic           n_talk;

    logic [7:0]     remapped;
    logic           key_push;
    logic [7:0]     key_byte;

    // Layout-mode remap of a pressed key by the modifier bit rules.
    function automatic logic [7:0] remap_key(input logic [7:0] k, input logic sh,
                                             input logic ct, input logic alt);
        logic       num;
        logic       zero;
        logic       sflag;
        logic       cflag;
        logic [7:0] r;
        num   = k[4] && !(sh && k[5]);
        zero  = !num && (k == 8'h30);
        sflag = !zero && (sh || k[5]);
        cflag = !ct && (k[6] || zero);
        r     = k;
        r[6]  = cflag;
        r[5]  = sflag;
        r[4]  = num || zero;
        if (zero) begin
            r[3:0] = 4'hF;
        end
        if (alt) begin
            r[7] = ~r[7];
        end
        return r;
    endfunction

    always_comb begin
        remapped = remap_key(i_item.in_byte, i_item.shift_held, i_item.ctrl_held,
                             i_item.alt_held);
        key_push = 1'b0;
        key_byte = i_item.in_byte;
        if (i_layout_mode) begin
            key_push = (i_item.event_kind == KIND_PRESS) && (i_item.in_byte != 8'd0);
            key_byte = remapped;
        end else begin
            key_push = (i_item.event_kind == KIND_TEXT);
        end
    end

    always_comb begin
        n_kq     = r_kq;
        n_cq     = r_cq;
        n_kc     = r_kc;
        n_cc     = r_cc;
        n_talk   = r_talk;
        o_result = '0;
        unique case (i_item.operation)
            OP_TICK: begin
                if (i_item.cpu_talk) begin
                    n_talk = 1'b0;
                end else begin
                    if (r_cc != '0) begin
                        if (r_cq[0] == CMD_ID) begin
                            for (int i = QUEUE_DEPTH - 1; i > 0; i--) begin
                                n_kq[i] = r_kq[i-1];
                            end
                            n_kq[0] = ID_BYTE;
                            if (r_kc < KCW'(QUEUE_DEPTH)) begin
                                n_kc = r_kc + 1'b1;
                            end
                        end
                        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                            n_cq[i] = r_cq[i+1];
                        end
                        n_cq[QUEUE_DEPTH-1] = 8'd0;
                        n_cc = r_cc - 1'b1;
                    end
                    if (n_kc != '0) begin
                        n_talk              = 1'b1;
                        o_result.byte_valid = 1'b1;
                        o_result.sent_byte  = n_kq[0];
                        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                            n_kq[i] = n_kq[i+1];
                        end
                        n_kq[QUEUE_DEPTH-1] = 8'd0;
                        n_kc = n_kc - 1'b1;
                    end else begin
                        n_talk = 1'b0;
                    end
                end
            end
            OP_HOST: begin
                if (!r_talk && i_item.cpu_talk && (r_cc < CW'(QUEUE_DEPTH - 1))) begin
                    n_cq[r_cc]        = i_item.in_byte;
                    n_cc              = r_cc + 1'b1;
                    o_result.accepted = 1'b1;
                end
            end
            OP_KEY: begin
                if (key_push && (r_kc < KCW'(QUEUE_DEPTH - 1))) begin
                    n_kq[r_kc[CW-1:0]] = key_byte;
                    n_kc               = r_kc + 1'b1;
                    o_result.accepted  = 1'b1;
                end
            end
            default: begin
            end
        endcase
        o_result.talk_line = n_talk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_kq[i] <= 8'd0;
                r_cq[i] <= 8'd0;
            end
            r_kc   <= '0;
            r_cc   <= '0;
            r_talk <= 1'b0;
        end else if (i_go) begin
            r_kq   <= n_kq;
            r_cq   <= n_cq;
            r_kc   <= n_kc;
            r_cc   <= n_cc;
            r_talk <= n_talk;
        end
    end

endmodule

// File: src/keyboard_fifo_talk_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_fifo_talk_controller
// Emulated keyboard with a key FIFO, a host command FIFO and a talk line.
// ----------------------------------------------------------------------------
// Channel   Direction  Words carried
// s_axis    in         one event, tick or host byte per word
// m_axis    out        one result per input word
// cfg       in         layout mode bit
//
// One word enters per cycle while s_axis_tready is high. Each word waits in the
// input register, and its result in the result register. The update of both
// queues and the talk flag is combinational between the two registers.
// Reset is synchronous and active low; it empties both queues and drops talk.
// A stalled result holds the input register, which in turn lowers s_axis_tready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyboard_fifo_talk_controller #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] cpu_talk, [8:1] in_byte, [9] shift_held, [10] ctrl_held,
    // [11] alt_held, [15:12] zero
    input  logic [15:0] s_axis_tdata,
    // [1:0] operation, [3:2] event_kind
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] byte_valid, [8:1] sent_byte, [9] talk_line, [10] accepted, [15:11] zero
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    import kftc_pkg::*;

    t_item   r_item;
    logic    r_in_valid;
    t_result r_res;
    logic    r_out_valid;
    logic    r_layout_mode;
    t_result n_res;
    logic    advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_layout_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.operation  <= t_op'(s_axis_tuser[1:0]);
            r_item.event_kind <= t_kind'(s_axis_tuser[3:2]);
            r_item.cpu_talk   <= s_axis_tdata[0];
            r_item.in_byte    <= s_axis_tdata[8:1];
            r_item.shift_held <= s_axis_tdata[9];
            r_item.ctrl_held  <= s_axis_tdata[10];
            r_item.alt_held   <= s_axis_tdata[11];
        end
    end

    kftc_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (advance),
        .i_layout_mode (r_layout_mode),
        .i_item        (r_item),
        .o_result      (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_res.accepted, r_res.talk_line, r_res.sent_byte,
                            r_res.byte_valid};

    // A byte is only ever sent with the talk line raised.
    `KFTC_ASSERT_SAME(a_sent_talks, m_axis_tvalid && r_res.byte_valid, r_res.talk_line)
    // No byte goes out on a result that is not a send.
    `KFTC_ASSERT_SAME(a_idle_byte_zero, m_axis_tvalid && !r_res.byte_valid,
                      r_res.sent_byte == 8'd0)
    // A tick never stores a byte, so a send and a store never coincide.
    `KFTC_ASSERT_ALWAYS(a_send_or_store, !(r_res.byte_valid && r_res.accepted) || !r_out_valid)
    // A held input word is not lost while the result side is stalled.
    `KFTC_ASSERT_NEXT(a_hold_input, r_in_valid && !advance, r_in_valid)

endmodule

// File: tb/sv/keyboard_fifo_talk_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_fifo_talk_controller_tb
// Drives key events, host bytes and ticks into the keyboard controller in both
// layout modes. Each word's result is predicted from a software copy of the
// key queue, the command queue and the talk flag, and compared field by field.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module keyboard_fifo_talk_controller_tb;
    import kftc_pkg::*;

    localparam int          DEPTH       = 8;
    localparam logic [7:0]  ZERO_KEY    = 8'h30;
    localparam int          PHASE_WORDS = 100;
    localparam int          CYCLE_LIMIT = 300000;

    typedef logic [7:0] t_fifo [DEPTH];

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata   = '0;
    logic [3:0]  s_axis_tuser   = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data     = 1'b0;

    // Software copy of the keyboard state.
    t_fifo       key_fifo;
    t_fifo       cmd_fifo;
    int          key_fill;
    int          cmd_fill;
    logic        talk_now;
    logic        layout_now;

    t_result     pending_results[$];
    int          error_count = 0;
    int          cycle_count = 0;
    logic        no_idle     = 1'b0;
    int          ready_run   = 0;

    keyboard_fifo_talk_controller #(
        .QUEUE_DEPTH(DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 99) < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    always @(negedge i_clk) begin
        if (no_idle) begin
            m_axis_tready <= 1'b1;
            ready_run     <= 0;
        end else if (ready_run == 0) begin
            if ($urandom_range(0, 99) < 65) begin
                m_axis_tready <= 1'b1;
                ready_run     <= $urandom_range(1, 8);
            end else begin
                m_axis_tready <= 1'b0;
                ready_run     <= gap_length();
            end
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    function automatic t_fifo shifted_out(t_fifo q);
        t_fifo r;
        for (int i = 0; i < DEPTH - 1; i++) begin
            r[i] = q[i + 1];
        end
        r[DEPTH - 1] = 8'h00;
        return r;
    endfunction

    function automatic logic remapped_press_store(logic [7:0] b);
        if (key_fill < DEPTH - 1) begin
            key_fifo[key_fill] = b;
            key_fill++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] remap_press(logic [7:0] k, logic sh, logic ct, logic alt);
        logic       num;
        logic       zero;
        logic [7:0] r;
        num  = k[4] && !(sh && k[5]);
        zero = !num && (k == ZERO_KEY);
        r    = k;
        r[6] = !ct && (k[6] || zero);
        r[5] = !zero && (sh || k[5]);
        r[4] = num || zero;
        if (zero) begin
            r[3:0] = 4'hF;
        end
        if (alt) begin
            r = r + 8'd128;
        end
        return r;
    endfunction

    // Applies one word to the state copy and returns the result it must produce.
    function automatic t_result keyboard_step(t_item it);
        t_result res;
        res = '0;
        case (it.operation)
            OP_TICK: begin
                if (it.cpu_talk) begin
                    talk_now = 1'b0;
                end else begin
                    if (cmd_fill > 0) begin
                        if (cmd_fifo[0] == CMD_ID) begin
                            for (int i = DEPTH - 1; i > 0; i--) begin
                                key_fifo[i] = key_fifo[i - 1];
                            end
                            key_fifo[0] = ID_BYTE;
                            if (key_fill < DEPTH) begin
                                key_fill++;
                            end
                        end
                        cmd_fifo = shifted_out(cmd_fifo);
                        cmd_fill--;
                    end
                    if (key_fill > 0) begin
                        talk_now       = 1'b1;
                        res.byte_valid = 1'b1;
                        res.sent_byte  = key_fifo[0];
                        key_fifo       = shifted_out(key_fifo);
                        key_fill--;
                    end else begin
                        talk_now = 1'b0;
                    end
                end
            end
            OP_HOST: begin
                if (!talk_now && it.cpu_talk && cmd_fill < DEPTH - 1) begin
                    cmd_fifo[cmd_fill] = it.in_byte;
                    cmd_fill++;
                    res.accepted = 1'b1;
                end
            end
            OP_KEY: begin
                if (layout_now) begin
                    if (it.event_kind == KIND_PRESS && it.in_byte != 8'h00) begin
                        res.accepted = remapped_press_store(remap_press(it.in_byte,
                            it.shift_held, it.ctrl_held, it.alt_held));
                    end
                end else if (it.event_kind == KIND_TEXT) begin
                    res.accepted = remapped_press_store(it.in_byte);
                end
            end
            default: ;
        endcase
        res.talk_line = talk_now;
        return res;
    endfunction

    function automatic t_item make_item(t_op op, logic cpu, t_kind kind, logic [7:0] b,
                                        logic sh, logic ct, logic alt);
        t_item it;
        it.operation  = op;
        it.cpu_talk   = cpu;
        it.event_kind = kind;
        it.in_byte    = b;
        it.shift_held = sh;
        it.ctrl_held  = ct;
        it.alt_held   = alt;
        return it;
    endfunction

    function automatic t_item random_item();
        return make_item(t_op'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
            t_kind'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // Entered and left at a falling edge; valid stays high between back-to-back words.
    task automatic send_word(t_item it);
        int gap;
        gap = (!no_idle && $urandom_range(0, 2) == 0) ? gap_length() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, it.alt_held, it.ctrl_held, it.shift_held, it.in_byte,
                          it.cpu_talk};
        s_axis_tuser  <= {it.event_kind, it.operation};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(keyboard_step(it));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // The result register sits behind the input register.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_layout(logic mode);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        layout_now = mode;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic report_fail(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[10:0]);
            if (pending_results.size() == 0) begin
                report_fail("result word with nothing pending");
            end else begin
                want = pending_results.pop_front();
                if (got.byte_valid !== want.byte_valid) begin
                    report_fail($sformatf("byte_valid got %b want %b",
                        got.byte_valid, want.byte_valid));
                end
                if (got.sent_byte !== want.sent_byte) begin
                    report_fail($sformatf("sent_byte got %02h want %02h",
                        got.sent_byte, want.sent_byte));
                end
                if (got.talk_line !== want.talk_line) begin
                    report_fail($sformatf("talk_line got %b want %b",
                        got.talk_line, want.talk_line));
                end
                if (got.accepted !== want.accepted) begin
                    report_fail($sformatf("accepted got %b want %b",
                        got.accepted, want.accepted));
                end
            end
        end
    end

    task automatic test_text_mode();
        write_layout(1'b0);
        // A zero character is queued like any other byte.
        send_word(make_item(OP_KEY, 1'b0, KIND_TEXT, 8'h00, 1'b0, 1'b0, 1'b0));
        send_word(make_item(OP_KEY, 1'b1, KIND_TEXT, 8'hFF, 1'b1, 1'b1, 1'b1));
        send_word(make_item(OP_KEY, 1'b0, KIND_PRESS, 8'h41, 1'b0, 1'b0, 1'b0));
        send_word(make_item(OP_KEY, 1'b0, KIND_RELEASE, 8'h41, 1'b0, 1'b0, 1'b0));
        send_word(make_item(OP_KEY, 1'b0, KIND_UNUSED, 8'h41, 1'b1, 1'b0, 1'b0));
        send_word(make_item(OP_NONE, 1'b1, KIND_TEXT, 8'hAA, 1'b1, 1'b1, 1'b1));
        repeat (3) send_word(make_item(OP_TICK, 1'b0, KIND_PRESS, 8'h00, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_layout_mode();
        write_layout(1'b1);
        send_word(make_item(OP_KEY, 1'b0, KIND_PRESS, ZERO_KEY, 1'b0, 1'b0, 1'b0));
        send_word(make_item(OP_KEY, 1'b0, KIND_PRESS, ZERO_KEY, 1'b1, 1'b0, 1'b0));
        send_word(make_item(OP_KEY, 1'b0, KIND_PRESS, 8'h7F, 1'b1, 1'b1, 1'b1));
        send_word(make_item(OP_KEY, 1'b0, KIND_PRESS, 8'h00, 1'b0, 1'b0, 1'b0));
        send_word(make_item(OP_KEY, 1'b0, KIND_TEXT, 8'h61, 1'b0, 1'b0, 1'b0));
        send_word(make_item(OP_KEY, 1'b0, KIND_RELEASE, 8'h55, 1'b0, 1'b0, 1'b0));
        send_word(make_item(OP_KEY, 1'b0, KIND_PRESS, 8'hFF, 1'b0, 1'b0, 1'b1));
        repeat (4) send_word(make_item(OP_TICK, 1'b0, KIND_PRESS, 8'h00, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_host_commands();
        // Dropping talk first lets host bytes in.
        send_word(make_item(OP_TICK, 1'b1, KIND_PRESS, 8'h00, 1'b0, 1'b0, 1'b0));
        send_word(make_item(OP_HOST, 1'b1, KIND_PRESS, CMD_ID, 1'b0, 1'b0, 1'b0));
        send_word(make_item(OP_HOST, 1'b0, KIND_PRESS, 8'h5A, 1'b0, 1'b0, 1'b0));
        send_word(make_item(OP_HOST, 1'b1, KIND_PRESS, 8'hFF, 1'b0, 1'b0, 1'b0));
        repeat (3) send_word(make_item(OP_TICK, 1'b0, KIND_PRESS, 8'h00, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_random_traffic();
        int    sent;
        int    len;
        int    pick;
        t_item it;
        for (int phase = 0; phase < 5; phase++) begin
            write_layout(phase == 4 ? 1'($urandom_range(0, 1)) : phase[0]);
            no_idle = (phase == 2);
            sent    = 0;
            while (sent < PHASE_WORDS) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    len = $urandom_range(1, 9);
                    repeat (len) begin
                        it = random_item();
                        if ($urandom_range(0, 99) < 85) begin
                            it.operation  = OP_KEY;
                            it.event_kind = layout_now ? KIND_PRESS : KIND_TEXT;
                        end
                        send_word(it);
                    end
                end else if (pick < 60) begin
                    len = $urandom_range(1, 8);
                    send_word(make_item(OP_TICK, 1'b1, KIND_PRESS, 8'h00, 1'b0, 1'b0, 1'b0));
                    repeat (len) begin
                        it           = random_item();
                        it.operation = OP_HOST;
                        it.cpu_talk  = 1'b1;
                        if ($urandom_range(0, 1)) begin
                            it.in_byte = CMD_ID;
                        end
                        send_word(it);
                    end
                    len++;
                end else if (pick < 90) begin
                    len = $urandom_range(1, 10);
                    repeat (len) begin
                        it           = random_item();
                        it.operation = OP_TICK;
                        it.cpu_talk  = 1'b0;
                        send_word(it);
                    end
                end else begin
                    len = $urandom_range(1, 3);
                    repeat (len) send_word(random_item());
                end
                sent += len;
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        key_fifo   = '{default: 8'h00};
        cmd_fifo   = '{default: 8'h00};
        key_fill   = 0;
        cmd_fill   = 0;
        talk_now   = 1'b0;
        layout_now = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_text_mode();
        test_layout_mode();
        test_host_commands();
        test_random_traffic();

        wait_idle();
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
